[src/fsqrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqrt_pkg
// Shared types and constants for the single-precision square root pipeline.
// ----------------------------------------------------------------------------
package fsqrt_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned RemW   = 28;
    localparam int unsigned QW     = 25;
    localparam int unsigned Steps  = 25;
    localparam int unsigned BitsPerStage = 5;
    localparam int unsigned Stages = Steps / BitsPerStage;

    localparam logic [31:0] SignMask = 32'h8000_0000;
    localparam logic [31:0] ExpMask  = 32'h7f80_0000;
    localparam logic [31:0] QuietNan = 32'h7fc0_0000;
    localparam logic [31:0] HalfBias = 32'h3f00_0000;

    localparam logic [1:0] RmNearest = 2'd0;
    localparam logic [1:0] RmZero    = 2'd1;
    localparam logic [1:0] RmDown    = 2'd2;
    localparam logic [1:0] RmUp      = 2'd3;

    localparam logic [0:0] RegRoundMode = 1'b0;

    // one item in flight through the recurrence
    typedef struct packed {
        logic          special;
        logic [31:0]   sbits;
        logic          invalid;
        logic [8:0]    half;     // signed exponent half
        logic [RemW-1:0] rem;
        logic [RemW-1:0] s;
        logic [QW-1:0] q;
        logic [1:0]    rmode;
    } t_item;

endpackage

[src/float32_square_root_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_square_root_top
// Pipelined IEEE-754 single-precision square root with rounding modes.
// ----------------------------------------------------------------------------
// Usage:
//   Operands enter on the s_axis channel (s_axis_tdata = operand bits) and
//   results leave on m_axis (tdata = root bits, tuser = {invalid, inexact}).
//   round_mode is written through the APB port at address 0; write it only
//   while the pipeline is empty. The mode is captured with each item.
//   An item passes unpack, five recurrence stages of five root bits each,
//   round and output registers before its result is offered. Throughput: one
//   item per cycle unless the output stalls; the recurrence depth sets the
//   latency, each stage holding five dependent subtract/compare steps.
//   When m_axis_tvalid is high and m_axis_tready low the whole pipeline
//   holds; s_axis_tready drops only then, when the output register is full
//   and not taken, so nothing is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits and sets
//   round_mode to nearest even.
// ----------------------------------------------------------------------------
module float32_square_root_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] root_bits
    output logic [1:0]  m_axis_tuser,   // [0] inexact, [1] invalid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned Ns = fsqrt_pkg::Stages;
    localparam int unsigned Bp = fsqrt_pkg::BitsPerStage;
    localparam int unsigned Rw = fsqrt_pkg::RemW;
    localparam int unsigned Qw = fsqrt_pkg::QW;

    logic [1:0] r_mode;
    logic       adv;

    assign pready = 1'b1;
    assign prdata = (paddr == fsqrt_pkg::RegRoundMode) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fsqrt_pkg::RmNearest;
        end else if (psel && penable && pwrite && paddr == fsqrt_pkg::RegRoundMode) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- stage 0: unpack and normalize ----------------
    fsqrt_pkg::t_item n_u, r_u;
    logic             r_uv;
    logic [4:0]       lz;
    logic [22:0]      frac;
    logic [23:0]      sig;
    logic [9:0]       unb;
    logic [7:0]       bexp;

    always_comb begin
        frac = s_axis_tdata[22:0];
        bexp = s_axis_tdata[30:23];
        lz   = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) lz = 5'(22 - i);
        end
        n_u = '0;
        n_u.rmode = r_mode;
        n_u.sbits = s_axis_tdata;
        if ((s_axis_tdata & ~fsqrt_pkg::SignMask) == 32'd0) begin
            n_u.special = 1'b1;
        end else if (s_axis_tdata[31]) begin
            n_u.special = 1'b1;
            n_u.invalid = 1'b1;
            n_u.sbits   = fsqrt_pkg::QuietNan;
        end else if ((s_axis_tdata & fsqrt_pkg::ExpMask) == fsqrt_pkg::ExpMask) begin
            n_u.special = 1'b1;
        end
        if (bexp == 8'd0) begin
            // subnormal: lz + 1 shifts bring the leading one to the hidden bit
            sig = {1'b0, frac} << (lz + 5'd1);
            unb = 10'(-10'sd127) - 10'(lz);
        end else begin
            sig = {1'b1, frac};
            unb = {2'b00, bexp} - 10'd127;
        end
        // rem = 2*sig, doubled again for odd exponent
        n_u.rem  = unb[0] ? Rw'({sig, 2'b00}) : Rw'({sig, 1'b0});
        n_u.half = unb[9:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_uv <= 1'b0;
        else if (adv) r_uv <= s_axis_tvalid;
        if (adv) r_u <= n_u;
    end

    // ---------------- recurrence stages ----------------
    fsqrt_pkg::t_item r_p [Ns+1];
    logic             r_pv [Ns+1];

    assign r_p[0]  = r_u;
    assign r_pv[0] = r_uv;

    for (genvar g = 0; g < Ns; g++) begin : g_stage
        fsqrt_pkg::t_item n_p;
        logic [Rw-1:0]    t;
        logic [Rw-1:0]    b;
        always_comb begin
            n_p = r_p[g];
            for (int k = 0; k < Bp; k++) begin
                b = Rw'(1) << (Qw - 1 - g * Bp - k);
                t = n_p.s + b;
                if (t <= n_p.rem) begin
                    n_p.s   = t + b;
                    n_p.rem = n_p.rem - t;
                    n_p.q   = n_p.q | Qw'(b);
                end
                n_p.rem = n_p.rem << 1;
            end
        end
        fsqrt_pkg::t_item r_q;
        logic             r_qv;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_qv <= 1'b0;
            else if (adv) r_qv <= r_pv[g];
            if (adv) r_q <= n_p;
        end
        assign r_p[g+1]  = r_q;
        assign r_pv[g+1] = r_qv;
    end

    // ---------------- round and pack ----------------
    fsqrt_pkg::t_item f;
    logic [Qw:0]  qr;
    logic [31:0]  n_root;
    logic         n_inx;
    logic [31:0]  r_root;
    logic [1:0]   r_flags;
    logic         r_ov;
    logic         r_rv;

    assign f = r_p[Ns];

    always_comb begin
        qr    = {1'b0, f.q};
        n_inx = (f.rem != '0);
        if (n_inx) begin
            if (f.rmode == fsqrt_pkg::RmNearest) qr = qr + (Qw + 1)'(f.q[0]);
            else if (f.rmode == fsqrt_pkg::RmUp) qr = qr + (Qw + 1)'(2);
        end
        n_root = 32'(qr[Qw:1]) + fsqrt_pkg::HalfBias + {f.half, 23'd0};
    end

    logic [31:0] r_froot;
    logic [1:0]  r_fflags;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rv <= 1'b0;
        else if (adv) r_rv <= r_pv[Ns];
        if (adv) begin
            r_froot  <= f.special ? f.sbits : n_root;
            r_fflags <= {f.invalid, f.special ? 1'b0 : n_inx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_rv;
        if (adv) begin
            r_root  <= r_froot;
            r_flags <= r_fflags;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_root;
    assign m_axis_tuser  = r_flags;

    // ---------------- assertions ----------------
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("invalid and inexact both set");
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == fsqrt_pkg::QuietNan)
        else $error("invalid result not quiet NaN");
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[31])
        else $error("rounded root negative");

endmodule
